### sv/batchnorm_inference_top_macros.svh
// Assertion helpers shared by the batch normalization block.
`ifndef BATCHNORM_INFERENCE_TOP_MACROS_SVH
`define BATCHNORM_INFERENCE_TOP_MACROS_SVH

// Base form: clocked on clk, off while rst is high.
`define BN_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Same-cycle implication.
`define BN_ASSERT_IMPLIES(label, a, c, msg) \
  `BN_ASSERT_RST(label, (a) |-> (c), msg)

// Next-cycle implication.
`define BN_ASSERT_NEXT(label, a, c, msg) \
  `BN_ASSERT_RST(label, (a) |=> (c), msg)

`endif

### sv/bn_pkg.sv
`default_nettype none
package bn_pkg;

  localparam int MAX_CHANNELS_DEF = 64;

  localparam int ENTRY_W = 64;  // {mean, bias, scale}

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_NUM_CHANNELS = 2'd0;
  localparam logic [1:0] REG_PLANE_SIZE   = 2'd1;
  localparam logic [1:0] REG_EPSILON      = 2'd2;

  localparam logic OP_PARAM  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_READ,
    ST_FIN
  } bn_state_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_SQRT,
    SC_DIV,
    SC_FIX,
    SC_DONE
  } sc_state_t;

  typedef struct packed {
    logic cap_en;
    logic mul_en;
    logic fin_en;
    logic last;
  } norm_ctl_t;

  typedef struct packed {
    logic out_free;
  } norm_sts_t;

endpackage
`default_nettype wire

### sv/bn_ram.sv
`default_nettype none
module bn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/bn_scale.sv
`default_nettype none
// scale = weight * 2^24 / floor(sqrt((var + eps) * 2^16)), one bit per cycle
module bn_scale
  import bn_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [15:0] weight,
  input  wire logic        [23:0] variance,
  input  wire logic        [23:0] epsilon,
  output logic                    done,
  output logic             [31:0] scale
);
  localparam logic [5:0] SQRT_LAST = 6'd20;
  localparam logic [5:0] DIV_LAST  = 6'd39;

  sc_state_t state, state_next;

  logic [5:0]  cnt;
  logic [41:0] rad;
  logic [23:0] srem;
  logic [20:0] root;
  logic [39:0] num;
  logic [21:0] drem;
  logic [39:0] quo;
  logic        neg;
  logic        wzero;

  logic [16:0] wneg;
  logic [15:0] wmag;
  logic [24:0] sum;
  logic [23:0] srem_sh, trial;
  logic [21:0] dsh, dsor;
  logic [40:0] mag;
  logic [31:0] mag_neg;

  assign wneg    = -{weight[15], weight};
  assign wmag    = weight[15] ? wneg[15:0] : weight;
  assign sum     = {1'b0, variance} + {1'b0, epsilon};
  assign srem_sh = {srem[21:0], rad[41:40]};
  assign trial   = {1'b0, root, 2'b01};
  assign dsh     = {drem[20:0], num[39]};
  assign dsor    = {1'b0, root};
  // magnitude of a negative quotient rounds up (toward minus infinity overall)
  assign mag     = {1'b0, quo} + {40'd0, (neg && (drem != '0))};
  assign mag_neg = -mag[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SC_IDLE: if (start) state_next = SC_SQRT;
      SC_SQRT: if (cnt == SQRT_LAST) state_next = SC_DIV;
      SC_DIV:  if (cnt == DIV_LAST) state_next = SC_FIX;
      SC_FIX:  state_next = SC_DONE;
      SC_DONE: state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      SC_DONE: done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      SC_IDLE: begin
        if (start) begin
          rad   <= {1'b0, sum, 16'd0};
          srem  <= '0;
          root  <= '0;
          cnt   <= '0;
          neg   <= weight[15];
          wzero <= (weight == '0);
          num   <= {wmag, 24'd0};
          drem  <= '0;
          quo   <= '0;
        end
      end
      SC_SQRT: begin
        if (srem_sh >= trial) begin
          srem <= srem_sh - trial;
          root <= {root[19:0], 1'b1};
        end else begin
          srem <= srem_sh;
          root <= {root[19:0], 1'b0};
        end
        rad <= {rad[39:0], 2'b00};
        cnt <= (cnt == SQRT_LAST) ? 6'd0 : cnt + 6'd1;
      end
      SC_DIV: begin
        if (dsh >= dsor) begin
          drem <= dsh - dsor;
          quo  <= {quo[38:0], 1'b1};
        end else begin
          drem <= dsh;
          quo  <= {quo[38:0], 1'b0};
        end
        num <= {num[38:0], 1'b0};
        cnt <= cnt + 6'd1;
      end
      SC_FIX: begin
        if (root == '0) begin
          // zero var+eps saturates by sign of the weight; a zero weight gives zero
          if (neg) begin
            scale <= 32'h8000_0000;
          end else if (wzero) begin
            scale <= 32'd0;
          end else begin
            scale <= 32'h7FFF_FFFF;
          end
        end else if (!neg) begin
          scale <= (quo > 40'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
        end else begin
          scale <= (mag > 41'h0_8000_0000) ? 32'h8000_0000 : mag_neg;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### sv/bn_norm.sv
`default_nettype none
// (x - mean) * scale + bias, floor to Q8.8, saturate; holds the result beat
module bn_norm
  import bn_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire norm_ctl_t          ctl,
  input  wire logic signed [15:0] sample,
  input  wire logic [ENTRY_W-1:0] entry,
  output norm_sts_t               sts,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic             [15:0] m_axis_tdata,  // out_value[15:0]
  output logic              [0:0] m_axis_tuser,  // saturated
  output logic                    m_axis_tlast
);
  logic signed [15:0] sample_r;
  logic               last_r;
  logic signed [48:0] prod;
  logic signed [15:0] bias_r;

  logic signed [15:0] mean_e, bias_e;
  logic signed [31:0] scale_e;
  logic signed [16:0] diff;
  logic signed [49:0] acc;
  logic signed [33:0] y;
  logic               hi, lo;

  assign mean_e  = entry[63:48];
  assign bias_e  = entry[47:32];
  assign scale_e = entry[31:0];
  assign diff    = 17'(sample_r) - 17'(mean_e);

  assign acc = 50'(prod) + {{18{bias_r[15]}}, bias_r, 16'd0};
  assign y   = acc[49:16];  // arithmetic shift = floor
  assign hi  = (y > 34'sd32767);
  assign lo  = (y < -34'sd32768);

  assign sts.out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (ctl.cap_en) begin
      sample_r <= sample;
      last_r   <= ctl.last;
    end
    if (ctl.mul_en) begin
      prod   <= 49'(diff) * 49'(scale_e);
      bias_r <= bias_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.fin_en && sts.out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin_en && sts.out_free) begin
      if (hi) begin
        m_axis_tdata <= 16'h7FFF;
      end else if (lo) begin
        m_axis_tdata <= 16'h8000;
      end else begin
        m_axis_tdata <= y[15:0];
      end
      m_axis_tuser <= hi || lo;
      m_axis_tlast <= last_r;
    end
  end

endmodule
`default_nettype wire

### sv/batchnorm_inference_top.sv
// Sample beat: the table entry is read as the beat is accepted, then the product is formed,
// then the result is rounded/saturated into the output register once that register is free;
// no new beat is accepted until then. Parameter beat: no new beat is accepted until the scale
// is done, set by the bit-serial square root (21 steps) and the restoring divider (40 steps).
// Reset (synchronous, active high) clears control state, counters and output valid, and sets
// the configuration registers to 1; the channel table holds no valid data until written.
`default_nettype none
module batchnorm_inference_top
  import bn_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // channel_index[5:0], mean_value[21:6], variance_value[45:22],
  // weight_value[61:46], bias_value[77:62], sample_value[93:78], zero[95:94]
  input  wire logic [95:0] s_axis_tdata,
  input  wire logic  [0:0] s_axis_tuser,  // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,  // out_value[15:0]
  output logic       [0:0] m_axis_tuser,  // saturated
  output logic             m_axis_tlast,  // last_of_tensor
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic  [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
`include "batchnorm_inference_top_macros.svh"

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [10:0] MAX_CH = 11'(MAX_CHANNELS);

  bn_state_t state, state_next;

  logic [6:0]  num_channels;
  logic [15:0] plane_size;
  logic [23:0] epsilon;
  logic [15:0] plane_position;
  logic [6:0]  current_channel;

  logic [AW-1:0]      wr_addr;
  logic               wr_ok;
  logic signed [15:0] wr_mean, wr_bias;

  logic        in_acc, acc_param, acc_sample;
  logic [5:0]  f_ch;
  logic [15:0] f_mean, f_weight, f_bias, f_sample;
  logic [23:0] f_var;

  logic [6:0]  eff_ch;
  logic [15:0] eff_plane;
  logic        end_plane, end_ch;
  logic [10:0] ch_ext, ch_sel, ci_ext;

  logic               scale_done;
  logic        [31:0] scale;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  norm_ctl_t          norm_ctl;
  norm_sts_t          norm_sts;

  assign f_ch     = s_axis_tdata[5:0];
  assign f_mean   = s_axis_tdata[21:6];
  assign f_var    = s_axis_tdata[45:22];
  assign f_weight = s_axis_tdata[61:46];
  assign f_bias   = s_axis_tdata[77:62];
  assign f_sample = s_axis_tdata[93:78];

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign acc_param  = in_acc && (s_axis_tuser[0] == OP_PARAM);
  assign acc_sample = in_acc && (s_axis_tuser[0] == OP_SAMPLE);

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels <= 7'd1;
      plane_size   <= 16'd1;
      epsilon      <= 24'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_NUM_CHANNELS: num_channels <= pwdata[6:0];
        REG_PLANE_SIZE:   plane_size   <= pwdata[15:0];
        REG_EPSILON:      epsilon      <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NUM_CHANNELS: prdata = {25'd0, num_channels};
      REG_PLANE_SIZE:   prdata = {16'd0, plane_size};
      REG_EPSILON:      prdata = {8'd0, epsilon};
      default:          prdata = 32'd0;
    endcase
  end

  // plane / channel counters
  always_comb begin
    if (num_channels == '0) begin
      eff_ch = 7'd1;
    end else if ({4'd0, num_channels} > MAX_CH) begin
      eff_ch = MAX_CH[6:0];
    end else begin
      eff_ch = num_channels;
    end
  end

  assign eff_plane = (plane_size == '0) ? 16'd1 : plane_size;
  assign end_plane = ({1'b0, plane_position} + 17'd1) >= {1'b0, eff_plane};
  assign end_ch    = ({1'b0, current_channel} + 8'd1) >= {1'b0, eff_ch};

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_position  <= '0;
      current_channel <= '0;
    end else if (acc_sample) begin
      if (end_plane) begin
        plane_position  <= '0;
        current_channel <= end_ch ? 7'd0 : current_channel + 7'd1;
      end else begin
        plane_position <= plane_position + 16'd1;
      end
    end
  end

  assign ch_ext = {4'd0, current_channel};
  assign ch_sel = (ch_ext < MAX_CH) ? ch_ext : 11'd0;
  assign ci_ext = {5'd0, f_ch};

  always_ff @(posedge clk) begin
    if (acc_param) begin
      wr_addr <= ci_ext[AW-1:0];
      wr_ok   <= (ci_ext < MAX_CH);
      wr_mean <= f_mean;
      wr_bias <= f_bias;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc_param) begin
          state_next = ST_SCALE;
        end else if (acc_sample) begin
          state_next = ST_READ;
        end
      end
      ST_SCALE: if (scale_done) state_next = ST_IDLE;
      ST_READ:  state_next = ST_FIN;
      ST_FIN:   if (norm_sts.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready   = 1'b0;
    ram_we          = 1'b0;
    norm_ctl.cap_en = acc_sample;
    norm_ctl.last   = end_plane && end_ch;
    norm_ctl.mul_en = 1'b0;
    norm_ctl.fin_en = 1'b0;
    case (state)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_SCALE: ram_we = scale_done && wr_ok;
      ST_READ:  norm_ctl.mul_en = 1'b1;
      ST_FIN:   norm_ctl.fin_en = 1'b1;
      default: ;
    endcase
  end

  bn_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .start    (acc_param),
    .weight   (f_weight),
    .variance (f_var),
    .epsilon  (epsilon),
    .done     (scale_done),
    .scale    (scale)
  );

  bn_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CHANNELS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata ({wr_mean, wr_bias, scale}),
    .raddr (ch_sel[AW-1:0]),
    .rdata (ram_rdata)
  );

  bn_norm u_norm (
    .clk           (clk),
    .rst           (rst),
    .ctl           (norm_ctl),
    .sample        (f_sample),
    .entry         (ram_rdata),
    .sts           (norm_sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `BN_ASSERT_NEXT(a_sample_reads, acc_sample, state == ST_READ, "sample beat did not start read")
  `BN_ASSERT_NEXT(a_param_scales, acc_param, state == ST_SCALE, "param beat did not start scale")
  `BN_ASSERT_IMPLIES(a_done_in_scale, scale_done, state == ST_SCALE, "scale done out of turn")
  `BN_ASSERT_NEXT(a_fin_loads, (state == ST_FIN) && norm_sts.out_free, m_axis_tvalid, "result lost")

endmodule
`default_nettype wire

### sim/tb_batchnorm_inference_top.sv
`default_nettype none
module tb_batchnorm_inference_top;
  import bn_pkg::*;

  localparam int TABLE_DEPTH   = MAX_CHANNELS_DEF;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic               op;
    logic        [5:0]  chan;
    logic signed [15:0] mean;
    logic        [23:0] variance;
    logic signed [15:0] weight;
    logic signed [15:0] bias;
    logic signed [15:0] sample;
  } bn_beat_t;

  typedef struct {
    logic [15:0] value;
    logic        sat;
    logic        last;
  } norm_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // channel_index, mean_value, variance_value, weight_value, bias_value, sample_value, zero
  logic [95:0] s_axis_tdata = '0;
  logic  [0:0] s_axis_tuser = '0;  // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // out_value
  logic  [0:0] m_axis_tuser;       // saturated
  logic        m_axis_tlast;       // last_of_tensor
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic  [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bn_beat_t     pending_beats[$];
  norm_result_t expected_norm[$];

  // predictor copy of the block
  int          tbl_mean  [TABLE_DEPTH];
  int          tbl_bias  [TABLE_DEPTH];
  int          tbl_scale [TABLE_DEPTH];
  int          pred_pos;
  int          pred_ch;
  logic  [6:0] cfg_num_ch;
  logic [15:0] cfg_plane;
  logic [23:0] cfg_eps;

  // stimulus-side tracking so that no sample lands on an unwritten channel
  int gen_pos;
  int gen_ch;
  bit ch_written [TABLE_DEPTH];

  bn_beat_t cur_beat;
  bit       offering;
  int       tx_wait;
  int       rx_wait;
  int       hold_left;
  bit       rx_ready;
  bit       no_idle;
  int       results_seen;
  int       mismatch_count;
  int       quiet_cycles;

  batchnorm_inference_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // weight / sqrt(var + eps) in Q16.16, floor division, saturated
  function automatic int gain_over_root(logic signed [15:0] w, logic [23:0] variance);
    longint unsigned sum;
    longint unsigned rad;
    longint unsigned root;
    longint unsigned trial;
    longint          num;
    longint          q;
    sum  = 64'(variance) + 64'(cfg_eps);
    rad  = sum << 16;
    root = 0;
    for (int b = 21; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= rad) root = trial;
    end
    if (root == 0) begin
      if (w > 0) return 32'h7fffffff;
      if (w < 0) return 32'h80000000;
      return 0;
    end
    num = longint'(w) * 16777216;
    q   = num / longint'(root);
    if (num < 0 && (num % longint'(root)) != 0) q = q - 1;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return int'(q);
  endfunction

  // plane/channel counters; returns 1 on the final sample of the tensor
  function automatic bit step_plane(ref int pos, ref int chan);
    int eff_ch;
    int eff_plane;
    bit end_plane;
    bit end_tensor;
    eff_ch = (cfg_num_ch == 0) ? 1 : int'(cfg_num_ch);
    if (eff_ch > TABLE_DEPTH) eff_ch = TABLE_DEPTH;
    eff_plane  = (cfg_plane == 0) ? 1 : int'(cfg_plane);
    end_plane  = pos + 1 >= eff_plane;
    end_tensor = end_plane && chan + 1 >= eff_ch;
    if (end_plane) begin
      pos  = 0;
      chan = (chan + 1 >= eff_ch) ? 0 : chan + 1;
    end else begin
      pos++;
    end
    return end_tensor;
  endfunction

  task automatic predict_beat(input bn_beat_t b);
    longint       diff;
    longint       acc;
    longint       y;
    norm_result_t r;
    if (b.op == OP_PARAM) begin
      tbl_mean[b.chan]  = b.mean;
      tbl_bias[b.chan]  = b.bias;
      tbl_scale[b.chan] = gain_over_root(b.weight, b.variance);
    end else begin
      diff  = longint'(b.sample) - longint'(tbl_mean[pred_ch]);
      acc   = diff * longint'(tbl_scale[pred_ch]) + longint'(tbl_bias[pred_ch]) * 65536;
      y     = acc >>> 16;
      r.sat = 1'b0;
      if (y > 32767) begin
        y     = 32767;
        r.sat = 1'b1;
      end else if (y < -32768) begin
        y     = -32768;
        r.sat = 1'b1;
      end
      r.value = y[15:0];
      r.last  = step_plane(pred_pos, pred_ch);
      expected_norm.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_result();
    norm_result_t want;
    if (expected_norm.size() == 0) begin
      report_mismatch($sformatf("unexpected beat data=%h", m_axis_tdata));
      return;
    end
    want = expected_norm.pop_front();
    if (m_axis_tdata !== want.value)
      report_mismatch($sformatf("out_value %h, want %h", m_axis_tdata, want.value));
    if (m_axis_tuser[0] !== want.sat)
      report_mismatch($sformatf("saturated %b, want %b", m_axis_tuser[0], want.sat));
    if (m_axis_tlast !== want.last)
      report_mismatch($sformatf("last_of_tensor %b, want %b", m_axis_tlast, want.last));
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      offering = 1'b0;
      tx_wait  = draw_gap();
      s_axis_tvalid <= 1'b0;
    end else begin
      if (offering && s_axis_tready) begin
        predict_beat(cur_beat);
        offering = 1'b0;
        tx_wait  = draw_gap();
      end
      if (!offering && pending_beats.size() != 0) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else begin
          cur_beat = pending_beats.pop_front();
          offering = 1'b1;
        end
      end
      s_axis_tvalid <= offering;
      if (offering) begin
        s_axis_tdata <= {2'b00, cur_beat.sample, cur_beat.bias, cur_beat.weight,
                         cur_beat.variance, cur_beat.mean, cur_beat.chan};
        s_axis_tuser <= cur_beat.op;
      end
    end
  end

  // receiver; two long hold-offs let the pipeline back up into the input
  always @(posedge clk) begin
    if (rst) begin
      rx_wait   = draw_gap();
      hold_left = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
        results_seen++;
        rx_wait = draw_gap();
        if (results_seen == 200 || results_seen == 900)
          hold_left = 300 + $urandom_range(0, 300);
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        rx_ready = 1'b0;
      end else begin
        rx_ready = 1'b1;
      end
      m_axis_tready <= rx_ready;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("tb_batchnorm_inference_top NOT OK");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_q88();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_variance();
    case ($urandom_range(0, 5))
      0:       return 24'h000000;
      1:       return 24'($urandom_range(0, 255));
      2:       return 24'hffffff;
      3:       return 24'($urandom_range(256, 65535));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic queue_param(input logic [5:0] chan, input logic [15:0] mean,
                             input logic [23:0] variance, input logic [15:0] weight,
                             input logic [15:0] bias);
    bn_beat_t b;
    b.op       = OP_PARAM;
    b.chan     = chan;
    b.mean     = mean;
    b.variance = variance;
    b.weight   = weight;
    b.bias     = bias;
    b.sample   = 16'($urandom);
    pending_beats.push_back(b);
    ch_written[chan] = 1'b1;
  endtask

  task automatic queue_sample(input logic [15:0] sample);
    bn_beat_t b;
    if (!ch_written[gen_ch])
      queue_param(6'(gen_ch), pick_q88(), pick_variance(), pick_q88(), pick_q88());
    b.op       = OP_SAMPLE;
    b.chan     = 6'($urandom);
    b.mean     = 16'($urandom);
    b.variance = 24'($urandom);
    b.weight   = 16'($urandom);
    b.bias     = 16'($urandom);
    b.sample   = sample;
    pending_beats.push_back(b);
    void'(step_plane(gen_pos, gen_ch));
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [6:0] nch, input logic [15:0] plane,
                            input logic [23:0] eps);
    apb_write(REG_NUM_CHANNELS, 32'(nch));
    cfg_num_ch = nch;
    apb_write(REG_PLANE_SIZE, 32'(plane));
    cfg_plane = plane;
    apb_write(REG_EPSILON, 32'(eps));
    cfg_eps = eps;
  endtask

  // parameter beats give no output, so wait out the scale computation too
  task automatic wait_drained();
    while (pending_beats.size() != 0 || offering || expected_norm.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [6:0] nch, input logic [15:0] plane,
                           input logic [23:0] eps, input int count, input bit burst);
    set_config(nch, plane, eps);
    no_idle = burst;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 12)
        queue_param(6'($urandom), pick_q88(), pick_variance(), pick_q88(), pick_q88());
      else
        queue_sample(pick_q88());
    end
    wait_drained();
  endtask

  initial begin
    cfg_num_ch     = 7'd1;
    cfg_plane      = 16'd1;
    cfg_eps        = 24'd1;
    pred_pos       = 0;
    pred_ch        = 0;
    gen_pos        = 0;
    gen_ch         = 0;
    no_idle        = 1'b0;
    results_seen   = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: zero var+eps saturating the scale both ways, output clipping,
    // zero weight, widest variance, negative scale rounding
    set_config(7'd2, 16'd3, 24'd0);
    queue_param(6'd0, 16'h0000, 24'h000000, 16'h7fff, 16'h0000);
    queue_param(6'd1, 16'h8000, 24'h000000, 16'h8000, 16'h7fff);
    queue_sample(16'h7fff);
    queue_sample(16'h8000);
    queue_sample(16'h0000);
    queue_sample(16'h7fff);
    queue_sample(16'h8000);
    queue_sample(16'h0000);
    queue_param(6'd0, 16'h7fff, 24'hffffff, 16'h7fff, 16'h8000);
    queue_param(6'd1, 16'h1234, 24'h000000, 16'h0000, 16'h0100);
    queue_sample(16'h8000);
    queue_sample(16'h7fff);
    queue_sample(16'h0001);
    queue_sample(16'hffff);
    queue_sample(16'h5a5a);
    queue_sample(16'h8000);
    queue_param(6'd0, 16'h0000, 24'h000001, 16'hffff, 16'h0000);
    queue_param(6'd1, 16'hff00, 24'h010000, 16'h0100, 16'h00ff);
    queue_sample(16'h0003);
    queue_sample(16'hfffd);
    queue_sample(16'h7fff);
    queue_sample(16'h0080);
    queue_sample(16'hff7f);
    queue_sample(16'h0000);
    wait_drained();

    run_phase(7'd4,   16'd5,     24'd1,       200, 1'b0);
    run_phase(7'd64,  16'd2,     24'hffffff,  250, 1'b1);
    run_phase(7'd1,   16'd1,     24'd0,       150, 1'b0);
    run_phase(7'd0,   16'd0,     24'd100,     100, 1'b0);
    run_phase(7'd127, 16'd3,     24'h010000,  200, 1'b1);
    // channel counter left above the new count
    run_phase(7'd2,   16'd7,     24'h000100,  150, 1'b0);
    run_phase(7'd3,   16'hffff,  24'd7,       150, 1'b0);
    // plane position left above the new plane size
    run_phase(7'd5,   16'd4,     24'd300,     200, 1'b0);
    run_phase(7'd64,  16'd1,     24'd0,       150, 1'b0);

    if (mismatch_count == 0) begin
      $display("tb_batchnorm_inference_top OK");
    end else begin
      $display("tb_batchnorm_inference_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
